// File: sv/aabb_overlap_resolve_defines.svh
// ----------------------------------------------------------------------------
// aabb_overlap_resolve_defines: assertion macros
// Wrappers for the concurrent checks of the overlap resolver; defining
// NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_RESOLVE_DEFINES_SVH
`define AABB_OVERLAP_RESOLVE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge while reset is released.
`define AOR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define AOR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AOR_ASSERT(lbl, clk, rst_n, prop, msg)
`define AOR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/aor_pkg.sv
// ----------------------------------------------------------------------------
// aor_pkg: shared definitions of the overlap resolver
// Widths, the contact side codes and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package aor_pkg;

	localparam int COORD_BITS      = 16;
	localparam int SHARE_FRAC_BITS = 8;
	localparam int SIZE_BITS       = COORD_BITS - 1;
	localparam int SHARE_BITS      = SHARE_FRAC_BITS + 1;
	// Doubled center offsets and doubled overlaps need three extra bits.
	localparam int D2_BITS         = COORD_BITS + 3;
	localparam int PROD_BITS       = SHARE_BITS + COORD_BITS;

	localparam logic [SHARE_BITS-1:0] SHARE_ONE = SHARE_BITS'(2 ** SHARE_FRAC_BITS);

	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_X_PLUS = 3'd1,
		SIDE_X_MINUS = 3'd2,
		SIDE_Y_PLUS = 3'd3,
		SIDE_Y_MINUS = 3'd4
	} side_t;

	typedef struct packed {
		logic signed [D2_BITS-1:0] ox2;
		logic signed [D2_BITS-1:0] oy2;
		logic                      dx_pos;
		logic                      dx_neg;
		logic                      dy_pos;
		logic                      dy_neg;
		logic [SHARE_BITS-1:0]     share_x;
		logic [SHARE_BITS-1:0]     share_y;
	} geo_t;

	typedef struct packed {
		logic                  hit;
		side_t                 side;
		logic [COORD_BITS-1:0] pen;
		logic [SHARE_BITS-1:0] share;
	} sel_t;

endpackage

`default_nettype wire

// File: sv/aor_geom.sv
// ----------------------------------------------------------------------------
// aor_geom: center offsets and overlaps
// Stage 1 forms the doubled center offsets and the size sums, stage 2 the
// doubled signed overlaps and the offset directions.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_geom (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] tile_left,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] tile_top,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         tile_width,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         tile_height,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] body_left,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] body_top,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         body_width,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         body_height,
	input  wire logic [aor_pkg::SHARE_BITS-1:0]        share_x,
	input  wire logic [aor_pkg::SHARE_BITS-1:0]        share_y,
	output logic                                       geo_valid,
	input  wire logic                                  geo_ready,
	output aor_pkg::geo_t                              geo
);

	localparam int DW = aor_pkg::D2_BITS;
	localparam int CW = aor_pkg::COORD_BITS;

	logic                          v_s1;
	logic signed [DW-1:0]          dx2_s1;
	logic signed [DW-1:0]          dy2_s1;
	logic [CW-1:0]                 wsum_s1;
	logic [CW-1:0]                 hsum_s1;
	logic [aor_pkg::SHARE_BITS-1:0] share_x_s1;
	logic [aor_pkg::SHARE_BITS-1:0] share_y_s1;
	logic                          v_s2;
	aor_pkg::geo_t                 geo_s2;

	logic                          ready_s1;
	logic                          ready_s2;
	logic signed [DW-1:0]          dx2_d;
	logic signed [DW-1:0]          dy2_d;
	logic signed [DW-1:0]          dx_abs;
	logic signed [DW-1:0]          dy_abs;
	aor_pkg::geo_t                 geo_d;

	assign ready_s2 = !v_s2 || geo_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Doubled centers: 2*left + width, so no half unit is ever lost.
	assign dx2_d = (DW'(tile_left) <<< 1) + $signed(DW'(tile_width))
		- (DW'(body_left) <<< 1) - $signed(DW'(body_width));
	assign dy2_d = (DW'(tile_top) <<< 1) + $signed(DW'(tile_height))
		- (DW'(body_top) <<< 1) - $signed(DW'(body_height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dx2_s1     <= dx2_d;
			dy2_s1     <= dy2_d;
			wsum_s1    <= CW'(tile_width) + CW'(body_width);
			hsum_s1    <= CW'(tile_height) + CW'(body_height);
			share_x_s1 <= (share_x > aor_pkg::SHARE_ONE) ? aor_pkg::SHARE_ONE : share_x;
			share_y_s1 <= (share_y > aor_pkg::SHARE_ONE) ? aor_pkg::SHARE_ONE : share_y;
		end
	end

	assign dx_abs = dx2_s1[DW-1] ? -dx2_s1 : dx2_s1;
	assign dy_abs = dy2_s1[DW-1] ? -dy2_s1 : dy2_s1;

	always_comb begin
		geo_d.ox2     = dx_abs - $signed(DW'(wsum_s1));
		geo_d.oy2     = dy_abs - $signed(DW'(hsum_s1));
		geo_d.dx_pos  = !dx2_s1[DW-1] && (dx2_s1 != '0);
		geo_d.dx_neg  = dx2_s1[DW-1];
		geo_d.dy_pos  = !dy2_s1[DW-1] && (dy2_s1 != '0);
		geo_d.dy_neg  = dy2_s1[DW-1];
		geo_d.share_x = share_x_s1;
		geo_d.share_y = share_y_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			geo_s2 <= geo_d;
		end
	end

	assign geo_valid = v_s2;
	assign geo       = geo_s2;

endmodule

`default_nettype wire

// File: sv/aor_select.sv
// ----------------------------------------------------------------------------
// aor_select: axis choice
// Stage 3 decides on collision, picks the axis of smaller penetration and
// forms the side code, the penetration depth and the share for that axis.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_select (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          geo_valid,
	output logic               geo_ready,
	input  wire aor_pkg::geo_t geo,
	output logic               sel_valid,
	input  wire logic          sel_ready,
	output aor_pkg::sel_t      sel
);

	localparam int DW = aor_pkg::D2_BITS;
	localparam int CW = aor_pkg::COORD_BITS;

	logic          v_s3;
	aor_pkg::sel_t sel_s3;
	logic          ready_s3;
	logic [DW-1:0] pen_x;
	logic [DW-1:0] pen_y;
	logic          use_x;
	aor_pkg::sel_t sel_d;

	assign ready_s3  = !v_s3 || sel_ready;
	assign geo_ready = ready_s3;

	assign pen_x = -geo.ox2;
	assign pen_y = -geo.oy2;
	assign use_x = $signed(geo.ox2) >= $signed(geo.oy2);

	always_comb begin
		sel_d.hit   = geo.ox2[DW-1] && geo.oy2[DW-1];
		sel_d.side  = aor_pkg::SIDE_NONE;
		sel_d.pen   = '0;
		sel_d.share = use_x ? geo.share_x : geo.share_y;
		if (sel_d.hit) begin
			if (use_x) begin
				if (geo.dx_pos) begin
					sel_d.side = aor_pkg::SIDE_X_PLUS;
				end else if (geo.dx_neg) begin
					sel_d.side = aor_pkg::SIDE_X_MINUS;
				end
				if (geo.dx_pos || geo.dx_neg) begin
					sel_d.pen = pen_x[CW-1:0];
				end
			end else begin
				if (geo.dy_pos) begin
					sel_d.side = aor_pkg::SIDE_Y_PLUS;
				end else if (geo.dy_neg) begin
					sel_d.side = aor_pkg::SIDE_Y_MINUS;
				end
				if (geo.dy_pos || geo.dy_neg) begin
					sel_d.pen = pen_y[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= geo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && geo_valid) begin
			sel_s3 <= sel_d;
		end
	end

	assign sel_valid = v_s3;
	assign sel       = sel_s3;

endmodule

`default_nettype wire

// File: sv/aor_scale.sv
// ----------------------------------------------------------------------------
// aor_scale: push split
// Stage 4 multiplies the penetration by the two shares, stage 5 scales,
// applies the push directions and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module aor_scale (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sel_valid,
	output logic                                sel_ready,
	input  wire aor_pkg::sel_t                  sel,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [aor_pkg::COORD_BITS-1:0] tile_move_x,
	output logic signed [aor_pkg::COORD_BITS-1:0] tile_move_y,
	output logic signed [aor_pkg::COORD_BITS-1:0] body_move_x,
	output logic signed [aor_pkg::COORD_BITS-1:0] body_move_y,
	output logic [2:0]                          contact_side,
	output logic                                collided
);

	localparam int CW = aor_pkg::COORD_BITS;
	localparam int PW = aor_pkg::PROD_BITS;

	logic             v_s4;
	logic             hit_s4;
	aor_pkg::side_t   side_s4;
	logic [PW-1:0]    tile_prod_s4;
	logic [PW-1:0]    body_prod_s4;
	logic             v_s5;
	logic             hit_s5;
	aor_pkg::side_t   side_s5;
	logic [CW-1:0]    tmx_s5;
	logic [CW-1:0]    tmy_s5;
	logic [CW-1:0]    bmx_s5;
	logic [CW-1:0]    bmy_s5;

	logic             ready_s4;
	logic             ready_s5;
	logic [CW-1:0]    tmag;
	logic [CW-1:0]    bmag;
	logic [CW-1:0]    tmx_d;
	logic [CW-1:0]    tmy_d;
	logic [CW-1:0]    bmx_d;
	logic [CW-1:0]    bmy_d;

	assign ready_s5  = !v_s5 || out_ready;
	assign ready_s4  = !v_s4 || ready_s5;
	assign sel_ready = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ready_s4) begin
			v_s4 <= sel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && sel_valid) begin
			hit_s4       <= sel.hit;
			side_s4      <= sel.side;
			tile_prod_s4 <= PW'(aor_pkg::SHARE_ONE - sel.share) * PW'(sel.pen);
			body_prod_s4 <= PW'(sel.share) * PW'(sel.pen);
		end
	end

	// Divide by twice the share unit; the products are magnitudes, so the
	// shift truncates toward zero and the result stays below half the range.
	assign tmag = tile_prod_s4[PW-1 -: CW];
	assign bmag = body_prod_s4[PW-1 -: CW];

	always_comb begin
		tmx_d = '0;
		tmy_d = '0;
		bmx_d = '0;
		bmy_d = '0;
		case (side_s4)
			aor_pkg::SIDE_X_PLUS: begin
				tmx_d = tmag;
				bmx_d = -bmag;
			end
			aor_pkg::SIDE_X_MINUS: begin
				tmx_d = -tmag;
				bmx_d = bmag;
			end
			aor_pkg::SIDE_Y_PLUS: begin
				tmy_d = tmag;
				bmy_d = -bmag;
			end
			aor_pkg::SIDE_Y_MINUS: begin
				tmy_d = -tmag;
				bmy_d = bmag;
			end
			default: begin
				tmx_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ready_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			hit_s5  <= hit_s4;
			side_s5 <= side_s4;
			tmx_s5  <= tmx_d;
			tmy_s5  <= tmy_d;
			bmx_s5  <= bmx_d;
			bmy_s5  <= bmy_d;
		end
	end

	assign out_valid    = v_s5;
	assign tile_move_x  = $signed(tmx_s5);
	assign tile_move_y  = $signed(tmy_s5);
	assign body_move_x  = $signed(bmx_s5);
	assign body_move_y  = $signed(bmy_s5);
	assign contact_side = side_s5;
	assign collided     = hit_s5;

endmodule

`default_nettype wire

// File: sv/aabb_overlap_resolve.sv
// ----------------------------------------------------------------------------
// aabb_overlap_resolve: minimum translation push for two axis-aligned boxes
// An accepted input transaction passes stages 1 to 5 in turn to its result.
// Throughput: one transaction per cycle unless the output stalls; five pipeline
// registers, one stage holding the two share multiplies.
// Reset: arst_n clears all stage valid bits asynchronously, payload is kept.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_overlap_resolve_defines.svh"

// The resolver works on doubled coordinates so that box centers stay exact.
// Stages:
//   1. Doubled center offsets (tile minus body), size sums and saturated shares.
//   2. Doubled overlaps: |offset| minus size sum; negative means penetration.
//   3. Collision test, axis choice (smaller penetration, x on a tie), side code.
//   4. Penetration times the tile share and times the body share.
//   5. Scaling by twice the share unit, push directions, output register.
// Every stage holds its own valid bit and only advances when the stage after
// it is empty or advancing, so a stall on the output side fills bubbles first
// and never drops or duplicates a transaction.
module aabb_overlap_resolve (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] tile_left,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] tile_top,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         tile_width,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         tile_height,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] body_left,
	input  wire logic signed [aor_pkg::COORD_BITS-1:0] body_top,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         body_width,
	input  wire logic [aor_pkg::SIZE_BITS-1:0]         body_height,
	input  wire logic [aor_pkg::SHARE_BITS-1:0]        share_x,
	input  wire logic [aor_pkg::SHARE_BITS-1:0]        share_y,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [aor_pkg::COORD_BITS-1:0]      tile_move_x,
	output logic signed [aor_pkg::COORD_BITS-1:0]      tile_move_y,
	output logic signed [aor_pkg::COORD_BITS-1:0]      body_move_x,
	output logic signed [aor_pkg::COORD_BITS-1:0]      body_move_y,
	output logic [2:0]                                 contact_side,
	output logic                                       collided
);

	localparam int CW = aor_pkg::COORD_BITS;

	logic          geo_valid;
	logic          geo_ready;
	aor_pkg::geo_t geo;
	logic          sel_valid;
	logic          sel_ready;
	aor_pkg::sel_t sel;

	// Geometry: stages 1 and 2.
	aor_geom u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tile_left   (tile_left),
		.tile_top    (tile_top),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.body_left   (body_left),
		.body_top    (body_top),
		.body_width  (body_width),
		.body_height (body_height),
		.share_x     (share_x),
		.share_y     (share_y),
		.geo_valid   (geo_valid),
		.geo_ready   (geo_ready),
		.geo         (geo)
	);

	// Axis selection: stage 3. A zero center offset on the chosen axis keeps
	// the collision flag but gives no side and a zero penetration, so both
	// moves come out as zero.
	aor_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.geo_valid (geo_valid),
		.geo_ready (geo_ready),
		.geo       (geo),
		.sel_valid (sel_valid),
		.sel_ready (sel_ready),
		.sel       (sel)
	);

	// Push split: stages 4 and 5. The tile takes (one - share) of the
	// penetration and the body takes share of it, pointing away from each
	// other. Neither move can exceed half the coordinate range, so no
	// saturation is needed.
	aor_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.sel_valid    (sel_valid),
		.sel_ready    (sel_ready),
		.sel          (sel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tile_move_x  (tile_move_x),
		.tile_move_y  (tile_move_y),
		.body_move_x  (body_move_x),
		.body_move_y  (body_move_y),
		.contact_side (contact_side),
		.collided     (collided)
	);

	// A result without collision carries no side and no move at all.
	`AOR_ASSERT(a_no_hit_no_move, clk, arst_n, out_valid && !collided |-> contact_side == aor_pkg::SIDE_NONE && tile_move_x == '0 && tile_move_y == '0 && body_move_x == '0 && body_move_y == '0, "move reported without collision")

	// An x resolution leaves the y moves untouched, and the other way round.
	`AOR_ASSERT(a_x_side_no_y, clk, arst_n, out_valid && (contact_side == aor_pkg::SIDE_X_PLUS || contact_side == aor_pkg::SIDE_X_MINUS) |-> tile_move_y == '0 && body_move_y == '0, "y move on an x contact")
	`AOR_ASSERT(a_y_side_no_x, clk, arst_n, out_valid && (contact_side == aor_pkg::SIDE_Y_PLUS || contact_side == aor_pkg::SIDE_Y_MINUS) |-> tile_move_x == '0 && body_move_x == '0, "x move on a y contact")

	// On an x plus contact the tile goes right and the body goes left.
	`AOR_ASSERT(a_x_plus_dir, clk, arst_n, out_valid && contact_side == aor_pkg::SIDE_X_PLUS |-> !tile_move_x[CW-1] && (body_move_x == '0 || body_move_x[CW-1]), "wrong push direction on x plus")

	// No result is offered while reset is held.
	`AOR_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

`default_nettype wire
